>>> sv/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

  localparam int unsigned OperandWidth = 64;
  localparam int unsigned ModWidth     = 63;
  localparam int unsigned ExpWidth     = 63;
  localparam int unsigned CntWidth     = $clog2(OperandWidth);

  // Request to the shared modular multiplier.
  typedef struct packed {
    logic                    start;
    logic [ModWidth-1:0]     a;
    logic [OperandWidth-1:0] b;
  } mm_req_t;

  // Status from the shared modular multiplier.
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [ModWidth-1:0] product;
  } mm_rsp_t;

endpackage

>>> sv/mexp_mulmod.sv
// Bit-serial shift-add modular multiplier, one multiplier bit per cycle.
module mexp_mulmod (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mexp_pkg::ModWidth-1:0]       m_i,
  input  mexp_pkg::mm_req_t                   req_i,
  output mexp_pkg::mm_rsp_t                   rsp_o
);

  localparam int unsigned SumWidth = mexp_pkg::ModWidth + 3;

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [mexp_pkg::CntWidth-1:0]       cnt_q, cnt_d;
  logic [mexp_pkg::ModWidth-1:0]       r_q, r_d;
  logic [mexp_pkg::ModWidth-1:0]       a_q, a_d;
  logic [mexp_pkg::OperandWidth-1:0]   b_q, b_d;

  logic [SumWidth-1:0] s0, s1, s2;
  logic [mexp_pkg::ModWidth-1:0] r_step;

  // 2r + bit*a is below 3m; pick the one of s, s-m, s-2m that lands in 0..m-1.
  always_comb begin
    s0 = {2'b00, r_q, 1'b0}
       + (b_q[mexp_pkg::OperandWidth-1] ? {3'b000, a_q} : {SumWidth{1'b0}});
    s1 = s0 - {3'b000, m_i};
    s2 = s0 - {2'b00, m_i, 1'b0};
    priority if (!s2[SumWidth-1]) begin
      r_step = s2[mexp_pkg::ModWidth-1:0];
    end else if (!s1[SumWidth-1]) begin
      r_step = s1[mexp_pkg::ModWidth-1:0];
    end else begin
      r_step = s0[mexp_pkg::ModWidth-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
    end else if (busy_q) begin
      r_d   = r_step;
      b_d   = {b_q[mexp_pkg::OperandWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mexp_pkg::CntWidth'(mexp_pkg::OperandWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = r_q;

endmodule

>>> sv/modular_exponentiation_top.sv
// Top level: base^exponent mod modulus by right-to-left square-and-multiply.
//
//   channel  direction  handshake                     payload
//   in       input      in_valid_i / in_stall_o       base_i, exponent_i
//   out      output     out_valid_o / out_stall_i     power_result_o
//   cfg      input      cfg_we_i                      cfg_wdata_i (modulus)
//
// Every modular product goes through one shared bit-serial multiplier, and the
// sequencer picks up each product when done rises. Base reduction is one pass;
// each exponent bit up to the highest set one costs a square (zero bit) or a
// multiply and a square (one bit), and StDone hands off the result. A modulus
// of 0 or 1 skips the multiplier and goes straight to StDone with result 0.
// in_stall_o is high while an item is at work; one finished result may wait in
// the output register while the next item runs.
// Reset clears control state and sets modulus 1.
module modular_exponentiation_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mexp_pkg::ModWidth-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mexp_pkg::OperandWidth-1:0] base_i,
  input  logic [mexp_pkg::ExpWidth-1:0]     exponent_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mexp_pkg::ModWidth-1:0]     power_result_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed  = 3'd1;  // base mod m in flight
  localparam logic [2:0] StLoop = 3'd2;  // pick next exponent step
  localparam logic [2:0] StMul  = 3'd3;  // res * a in flight
  localparam logic [2:0] StSqr  = 3'd4;  // a * a in flight
  localparam logic [2:0] StDone = 3'd5;  // wait for free output register

  logic [2:0]                        state_q, state_d;
  logic [mexp_pkg::ModWidth-1:0]     modulus_q;
  logic [mexp_pkg::ExpWidth-1:0]     x_q, x_d;
  logic [mexp_pkg::ModWidth-1:0]     a_q, a_d;
  logic [mexp_pkg::ModWidth-1:0]     res_q, res_d;
  logic                              neg_q, neg_d;
  logic                              out_valid_q, out_valid_d;
  logic [mexp_pkg::ModWidth-1:0]     out_q, out_d;

  logic                              in_beat;
  logic                              mod_trivial;
  logic [mexp_pkg::OperandWidth-1:0] base_mag;
  logic [mexp_pkg::ModWidth-1:0]     base_fix;

  mexp_pkg::mm_req_t mm_req;
  mexp_pkg::mm_rsp_t mm_rsp;

  mexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .m_i    (modulus_q),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign mod_trivial = (modulus_q[mexp_pkg::ModWidth-1:1] == '0);

  // Magnitude of the signed base; the most negative value comes out as 2^63.
  assign base_mag = base_i[mexp_pkg::OperandWidth-1]
                  ? (mexp_pkg::OperandWidth'(0) - base_i) : base_i;

  // A negative base with nonzero remainder folds to m - rem.
  assign base_fix = (neg_q && (mm_rsp.product != '0))
                  ? (modulus_q - mm_rsp.product) : mm_rsp.product;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    a_d         = a_q;
    res_d       = res_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mm_req.start = 1'b0;
    mm_req.a     = a_q;
    mm_req.b     = {1'b0, a_q};

    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          x_d   = exponent_i;
          neg_d = base_i[mexp_pkg::OperandWidth-1];
          if (mod_trivial) begin
            res_d   = '0;
            state_d = StDone;
          end else begin
            // Horner pass with a = 1 gives |base| mod m.
            mm_req.start = 1'b1;
            mm_req.a     = mexp_pkg::ModWidth'(1);
            mm_req.b     = base_mag;
            state_d      = StRed;
          end
        end
      end
      StRed: begin
        if (mm_rsp.done) begin
          a_d     = base_fix;
          res_d   = mexp_pkg::ModWidth'(1);
          state_d = StLoop;
        end
      end
      StLoop: begin
        if (x_q == '0) begin
          state_d = StDone;
        end else if (x_q[0]) begin
          mm_req.start = 1'b1;
          mm_req.a     = res_q;
          state_d      = StMul;
        end else begin
          mm_req.start = 1'b1;
          state_d      = StSqr;
        end
      end
      StMul: begin
        if (mm_rsp.done) begin
          res_d        = mm_rsp.product;
          mm_req.start = 1'b1;
          state_d      = StSqr;
        end
      end
      StSqr: begin
        if (mm_rsp.done) begin
          a_d     = mm_rsp.product;
          x_d     = {1'b0, x_q[mexp_pkg::ExpWidth-1:1]};
          state_d = StLoop;
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      modulus_q   <= mexp_pkg::ModWidth'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    a_q   <= a_d;
    res_q <= res_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

`ifndef SYNTHESIS
  // A delivered result always lies in 0..m-1 (0 for a trivial modulus).
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((power_result_o < modulus_q) ||
                     (mod_trivial && (power_result_o == '0))))
    else $error("result outside modulus range");

  // The multiplier is never restarted while it is still working.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  // A product only comes back in a state that waits for one.
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> ((state_q == StRed) || (state_q == StMul) ||
                     (state_q == StSqr)))
    else $error("unexpected multiplier result");

  // Running values stay reduced once the loop is entered.
  a_loop_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoop) |-> ((a_q < modulus_q) && (res_q < modulus_q)))
    else $error("loop operands not reduced");
`endif

endmodule
